// ----- design/nearest_point_table_top_assert.svh -----
// Assertion macros used by the checker file of the nearest point table.
`ifndef NEAREST_POINT_TABLE_TOP_ASSERT_SVH
`define NEAREST_POINT_TABLE_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define NPT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nearest point table check failed");

// The consequent holds in the cycle after the antecedent.
`define NPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nearest point table check failed");

`endif

// ----- design/npt_pkg.sv -----
`default_nettype none

package npt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int OP_W     = 2;
   localparam int COORD_W  = 16;
   localparam int ID_W     = 32;
   localparam int COST_W   = 32;
   localparam int METRIC_W = 34;
   localparam int STATUS_W = 2;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int SQ_W     = 2 * COORD_W + 1;

   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_NEAREST = 2'd1;
   localparam logic [OP_W-1:0] OP_MINCOST = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] KIND_ZERO  = 2'd0;
   localparam logic [1:0] KIND_FULL  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_BEST  = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [ID_W-1:0]           node_id;
      logic [COST_W-1:0]         entry_cost;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      entry_type       entry;
   } req_type;

   typedef struct packed {
      logic       load;
      logic       write;
      logic       scan_start;
      logic       scan_step;
      logic       respond;
      logic [1:0] kind;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            full;
      logic            scan_last;
      logic            pipe_busy;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- design/npt_ram.sv -----
`default_nettype none

module npt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/npt_datapath.sv -----
`default_nettype none

module npt_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [npt_pkg::OP_W-1:0]            req_op,
   input  wire logic signed [npt_pkg::COORD_W-1:0]  req_pos_x,
   input  wire logic signed [npt_pkg::COORD_W-1:0]  req_pos_y,
   input  wire logic [npt_pkg::ID_W-1:0]            req_node_id,
   input  wire logic [npt_pkg::COST_W-1:0]          req_entry_cost,
   input  wire npt_pkg::cmd_type                    cmd,
   output npt_pkg::ctrl_status_type                 status,
   output logic                                     rsp_valid,
   output logic [npt_pkg::ID_W-1:0]                 rsp_found_id,
   output logic [npt_pkg::METRIC_W-1:0]             rsp_metric,
   output logic [npt_pkg::STATUS_W-1:0]             rsp_status
);

   import npt_pkg::*;

   req_type                  req_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [ADDR_W-1:0]        addr_ff;
   logic [ADDR_W-1:0]        addr_in;
   entry_type                rd_entry;
   logic                     rd_valid_ff;

   logic signed [DIFF_W-1:0] diff_x;
   logic signed [DIFF_W-1:0] diff_y;
   logic signed [2*DIFF_W-1:0] prod_x;
   logic signed [2*DIFF_W-1:0] prod_y;

   logic                     b_valid_ff;
   logic [SQ_W-1:0]          sq_x_ff;
   logic [SQ_W-1:0]          sq_y_ff;
   logic [COST_W-1:0]        b_cost_ff;
   logic [ID_W-1:0]          b_id_ff;

   logic [METRIC_W-1:0]      cand_metric;
   logic                     take_cand;
   logic                     best_valid_ff;
   logic                     best_valid_in;
   logic [METRIC_W-1:0]      best_metric_ff;
   logic [ID_W-1:0]          best_id_ff;

   logic                     rsp_valid_ff;
   logic [ID_W-1:0]          rsp_id_ff;
   logic [ID_W-1:0]          rsp_id_in;
   logic [METRIC_W-1:0]      rsp_metric_ff;
   logic [METRIC_W-1:0]      rsp_metric_in;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [STATUS_W-1:0]      rsp_status_in;

   npt_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_ff.entry),
      .rd_en   (cmd.scan_step),
      .rd_addr (addr_ff),
      .rd_data (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff.op               <= req_op;
         req_ff.entry.pos_x      <= req_pos_x;
         req_ff.entry.pos_y      <= req_pos_y;
         req_ff.entry.node_id    <= req_node_id;
         req_ff.entry.entry_cost <= req_entry_cost;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.write) begin
         count_in = count_ff + CNT_W'(1);
      end
      addr_in = addr_ff;
      if (cmd.scan_start) begin
         addr_in = '0;
      end else if (cmd.scan_step) begin
         addr_in = addr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
         b_valid_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         addr_ff     <= addr_in;
         rd_valid_ff <= cmd.scan_step;
         b_valid_ff  <= rd_valid_ff;
      end
   end

   assign diff_x = DIFF_W'(rd_entry.pos_x) - DIFF_W'(req_ff.entry.pos_x);
   assign diff_y = DIFF_W'(rd_entry.pos_y) - DIFF_W'(req_ff.entry.pos_y);
   assign prod_x = diff_x * diff_x;
   assign prod_y = diff_y * diff_y;

   always_ff @(posedge clock) begin
      sq_x_ff   <= prod_x[SQ_W-1:0];
      sq_y_ff   <= prod_y[SQ_W-1:0];
      b_cost_ff <= rd_entry.entry_cost;
      b_id_ff   <= rd_entry.node_id;
   end

   always_comb begin
      if (req_ff.op == OP_NEAREST) begin
         cand_metric = METRIC_W'(sq_x_ff) + METRIC_W'(sq_y_ff);
      end else begin
         cand_metric = METRIC_W'(b_cost_ff);
      end
      take_cand     = b_valid_ff && (!best_valid_ff || (cand_metric < best_metric_ff));
      best_valid_in = best_valid_ff;
      if (cmd.scan_start) begin
         best_valid_in = 1'b0;
      end else if (take_cand) begin
         best_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else begin
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_cand) begin
         best_metric_ff <= cand_metric;
         best_id_ff     <= b_id_ff;
      end
   end

   always_comb begin
      rsp_id_in     = '0;
      rsp_metric_in = '0;
      rsp_status_in = STATUS_OK;
      unique case (cmd.kind)
         KIND_ZERO: begin
            rsp_status_in = STATUS_OK;
         end
         KIND_FULL: begin
            rsp_status_in = STATUS_FULL;
         end
         KIND_EMPTY: begin
            rsp_status_in = STATUS_EMPTY;
         end
         KIND_BEST: begin
            rsp_id_in     = best_id_ff;
            rsp_metric_in = best_metric_ff;
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_id_ff     <= rsp_id_in;
         rsp_metric_ff <= rsp_metric_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign status.op        = req_ff.op;
   assign status.empty     = (count_ff == '0);
   assign status.full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign status.scan_last = (CNT_W'(addr_ff) == (count_ff - CNT_W'(1)));
   assign status.pipe_busy = rd_valid_ff || b_valid_ff;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found_id = rsp_id_ff;
   assign rsp_metric   = rsp_metric_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

`default_nettype wire

// ----- design/npt_ctrl.sv -----
`default_nettype none

module npt_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire npt_pkg::ctrl_status_type  status,
   output logic                           busy,
   output npt_pkg::cmd_type               cmd
);

   import npt_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_DRAIN  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op) inside
               OP_INSERT: begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
                  if (status.full) begin
                     cmd.kind = KIND_FULL;
                  end else begin
                     cmd.write = 1'b1;
                     cmd.kind  = KIND_ZERO;
                  end
               end
               OP_NEAREST, OP_MINCOST: begin
                  if (status.empty) begin
                     cmd.respond = 1'b1;
                     cmd.kind    = KIND_EMPTY;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               default: begin
                  cmd.respond = 1'b1;
                  cmd.kind    = KIND_ZERO;
                  state_in    = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.respond = 1'b1;
               cmd.kind    = KIND_BEST;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ----- design/nearest_point_table_top.sv -----
// Channel   Handshake          Beat carries
// request   start && !busy     req_op, req_pos_x, req_pos_y, req_node_id, req_entry_cost
// response  rsp_valid          rsp_found_id, rsp_metric, rsp_status
//
// Insert, unused op and empty or full cases: the decode state issues the result beat.
// A query over n stored entries steps through them in the scan state, then drains,
// using the single read port of the entry RAM, one entry per cycle.
// Reset is synchronous and clears the entry count; the table needs no clearing pass.
// The receiver cannot stall; each result beat stands for one cycle only.
`default_nettype none

module nearest_point_table_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [npt_pkg::OP_W-1:0]            req_op,
   input  wire logic signed [npt_pkg::COORD_W-1:0]  req_pos_x,
   input  wire logic signed [npt_pkg::COORD_W-1:0]  req_pos_y,
   input  wire logic [npt_pkg::ID_W-1:0]            req_node_id,
   input  wire logic [npt_pkg::COST_W-1:0]          req_entry_cost,
   output logic                                     rsp_valid,
   output logic [npt_pkg::ID_W-1:0]                 rsp_found_id,
   output logic [npt_pkg::METRIC_W-1:0]             rsp_metric,
   output logic [npt_pkg::STATUS_W-1:0]             rsp_status
);

   import npt_pkg::*;

   cmd_type         cmd;
   ctrl_status_type status;

   npt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   npt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_node_id    (req_node_id),
      .req_entry_cost (req_entry_cost),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_found_id   (rsp_found_id),
      .rsp_metric     (rsp_metric),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

// ----- design/nearest_point_table_checker.sv -----
`default_nettype none

`include "nearest_point_table_top_assert.svh"

module nearest_point_table_assertions (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           rsp_valid,
   input wire logic [npt_pkg::ID_W-1:0]       rsp_found_id,
   input wire logic [npt_pkg::METRIC_W-1:0]   rsp_metric,
   input wire logic [npt_pkg::STATUS_W-1:0]   rsp_status
);

   import npt_pkg::*;

   logic status_known;
   logic error_beat;
   logic error_fields_zero;

   assign status_known      = (rsp_status == STATUS_OK) || (rsp_status == STATUS_EMPTY)
                              || (rsp_status == STATUS_FULL);
   assign error_beat        = rsp_valid && (rsp_status != STATUS_OK);
   assign error_fields_zero = (rsp_found_id == '0) && (rsp_metric == '0);

   `NPT_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy)
   `NPT_ASSERT_SAME(a_result_when_idle, clock, reset, rsp_valid, !busy)
   `NPT_ASSERT_NEXT(a_single_beat, clock, reset, rsp_valid, !rsp_valid)
   `NPT_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, status_known)
   `NPT_ASSERT_SAME(a_error_zero, clock, reset, error_beat, error_fields_zero)

endmodule

bind nearest_point_table_top nearest_point_table_assertions u_checker (.*);

`default_nettype wire

// ----- tb/nearest_point_table_checker.sv -----
`timescale 1ns / 100ps

module nearest_point_table_checker
   import npt_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire logic [OP_W-1:0]            req_op,
   input  wire logic signed [COORD_W-1:0]  req_pos_x,
   input  wire logic signed [COORD_W-1:0]  req_pos_y,
   input  wire logic [ID_W-1:0]            req_node_id,
   input  wire logic [COST_W-1:0]          req_entry_cost,
   input  wire logic                       rsp_valid,
   input  wire logic [ID_W-1:0]            rsp_found_id,
   input  wire logic [METRIC_W-1:0]        rsp_metric,
   input  wire logic [STATUS_W-1:0]        rsp_status,
   output int                              failures,
   output int                              pending
);

   typedef struct packed {
      logic [ID_W-1:0]     found_id;
      logic [METRIC_W-1:0] metric;
      logic [STATUS_W-1:0] status;
   } answer_type;

   entry_type  stored [TABLE_DEPTH];
   int         stored_count = 0;
   answer_type answers_due [$];
   int         fail_count = 0;

   function automatic logic [METRIC_W-1:0] score(input logic [OP_W-1:0] op,
                                                 input entry_type held,
                                                 input entry_type query);
      longint dx;
      longint dy;
      if (op == OP_NEAREST) begin
         dx = longint'($signed(held.pos_x)) - longint'($signed(query.pos_x));
         dy = longint'($signed(held.pos_y)) - longint'($signed(query.pos_y));
         return METRIC_W'(dx * dx + dy * dy);
      end
      return METRIC_W'(held.entry_cost);
   endfunction

   // Applies one request to the shadow table and returns the answer it should produce.
   function automatic answer_type serve_request(input logic [OP_W-1:0] op,
                                                input entry_type query);
      answer_type          ans;
      logic [METRIC_W-1:0] best;
      logic [METRIC_W-1:0] cand;
      int                  pick;
      ans = '0;
      case (op)
         OP_INSERT: begin
            if (stored_count >= TABLE_DEPTH) begin
               ans.status = STATUS_FULL;
            end else begin
               stored[stored_count] = query;
               stored_count++;
            end
         end
         OP_NEAREST, OP_MINCOST: begin
            if (stored_count == 0) begin
               ans.status = STATUS_EMPTY;
            end else begin
               pick = 0;
               best = score(op, stored[0], query);
               for (int i = 1; i < stored_count; i++) begin
                  cand = score(op, stored[i], query);
                  if (cand < best) begin
                     best = cand;
                     pick = i;
                  end
               end
               ans.found_id = stored[pick].node_id;
               ans.metric   = best;
               ans.status   = STATUS_OK;
            end
         end
         default: begin
            ans = '0;
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      answer_type fresh;
      entry_type  query;
      if (!reset) begin
         if (rsp_valid) begin
            got.found_id = rsp_found_id;
            got.metric   = rsp_metric;
            got.status   = rsp_status;
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected beat: expected none, actual id %h metric %h status %0d",
                        $time, got.found_id, got.metric, got.status);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (got.found_id !== want.found_id) begin
                  $display("%0t: found_id mismatch: expected %h, actual %h",
                           $time, want.found_id, got.found_id);
                  fail_count++;
               end
               if (got.metric !== want.metric) begin
                  $display("%0t: metric mismatch: expected %h, actual %h",
                           $time, want.metric, got.metric);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            query.pos_x      = req_pos_x;
            query.pos_y      = req_pos_y;
            query.node_id    = req_node_id;
            query.entry_cost = req_entry_cost;
            fresh            = serve_request(req_op, query);
            answers_due.insert(answers_due.size(), fresh);
         end
      end
      failures <= fail_count;
      pending  <= answers_due.size();
   end

endmodule

// ----- tb/tb_nearest_point_table_top.sv -----
`timescale 1ns / 100ps

module tb_nearest_point_table_top;
   import npt_pkg::*;

   localparam int ITEM_TARGET    = 1900;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = TABLE_DEPTH + 16;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      start          = 1'b0;
   logic [OP_W-1:0]           req_op         = OP_INSERT;
   logic signed [COORD_W-1:0] req_pos_x      = '0;
   logic signed [COORD_W-1:0] req_pos_y      = '0;
   logic [ID_W-1:0]           req_node_id    = '0;
   logic [COST_W-1:0]         req_entry_cost = '0;
   logic                      busy;
   logic                      rsp_valid;
   logic [ID_W-1:0]           rsp_found_id;
   logic [METRIC_W-1:0]       rsp_metric;
   logic [STATUS_W-1:0]       rsp_status;
   int                        failures;
   int                        pending;
   int                        idle_cycles = 0;

   logic [COORD_W-1:0] placed_x [$];
   logic [COORD_W-1:0] placed_y [$];
   logic [ID_W-1:0]    placed_ids [$];
   logic [COST_W-1:0]  placed_costs [$];

   nearest_point_table_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_node_id    (req_node_id),
      .req_entry_cost (req_entry_cost),
      .rsp_valid      (rsp_valid),
      .rsp_found_id   (rsp_found_id),
      .rsp_metric     (rsp_metric),
      .rsp_status     (rsp_status)
   );

   nearest_point_table_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_node_id    (req_node_id),
      .req_entry_cost (req_entry_cost),
      .rsp_valid      (rsp_valid),
      .rsp_found_id   (rsp_found_id),
      .rsp_metric     (rsp_metric),
      .rsp_status     (rsp_status),
      .failures       (failures),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [ID_W-1:0] id,
                            input logic [COST_W-1:0] cost);
      req_op         <= op;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_node_id    <= id;
      req_entry_cost <= cost;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      if (op == OP_INSERT) begin
         placed_x.insert(placed_x.size(), x);
         placed_y.insert(placed_y.size(), y);
         placed_ids.insert(placed_ids.size(), id);
         placed_costs.insert(placed_costs.size(), cost);
      end
   endtask

   task automatic rest(input bit burst);
      int r;
      int gap;
      r = $urandom_range(0, 99);
      if (burst || r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 120);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic pick_point(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
      int r;
      int k;
      r = $urandom_range(0, 99);
      if (r < 30 || (r >= 75 && placed_x.size() == 0)) begin
         x = COORD_W'($urandom);
         y = COORD_W'($urandom);
      end else if (r < 45) begin
         x = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7fff;
         y = ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000;
         if ($urandom_range(0, 1) == 1) begin
            x = ~x;
            y = ~y;
         end
      end else if (r < 75) begin
         x = COORD_W'($urandom_range(0, 128)) - 16'd64;
         y = COORD_W'($urandom_range(0, 128)) - 16'd64;
      end else begin
         k = $urandom_range(0, placed_x.size() - 1);
         x = placed_x[k] + COORD_W'($urandom_range(0, 4)) - 16'd2;
         y = placed_y[k] + COORD_W'($urandom_range(0, 4)) - 16'd2;
      end
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15 && placed_ids.size() != 0) begin
         return placed_ids[$urandom_range(0, placed_ids.size() - 1)];
      end
      if (r < 25) return ($urandom_range(0, 1) == 1) ? 32'hffff_ffff : 32'h0;
      return $urandom;
   endfunction

   function automatic logic [COST_W-1:0] pick_cost();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return $urandom;
      if (r < 55) return $urandom_range(0, 15);
      if (r < 70 && placed_costs.size() != 0) begin
         return placed_costs[$urandom_range(0, placed_costs.size() - 1)];
      end
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'h7fff_ffff;
            default: return 32'h8000_0000;
         endcase
      end
      return $urandom >> $urandom_range(0, 31);
   endfunction

   initial begin
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      bit                 burst;
      int                 r;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Queries and the unused code against an empty table.
      send_item(OP_NEAREST, 16'h8000, 16'h7fff, 32'hffff_ffff, 32'hffff_ffff); rest(0);
      send_item(OP_MINCOST, 16'h7fff, 16'h8000, 32'h0, 32'h0);                 rest(0);
      send_item(OP_UNUSED,  16'h1234, 16'h4321, 32'h5555_5555, 32'haaaa_aaaa); rest(0);
      // Field extremes, including the largest possible distance.
      send_item(OP_INSERT,  16'h8000, 16'h8000, 32'hffff_ffff, 32'hffff_ffff); rest(0);
      send_item(OP_NEAREST, 16'h7fff, 16'h7fff, 32'h0, 32'h0);                 rest(0);
      send_item(OP_MINCOST, 16'h0, 16'h0, 32'h0, 32'h0);                       rest(0);
      send_item(OP_INSERT,  16'h7fff, 16'h7fff, 32'h0, 32'h0);                 rest(0);
      // Equal costs and equal points must resolve to the earliest entry;
      // a repeated id is stored as a separate entry.
      send_item(OP_INSERT,  16'h0, 16'h0, 32'h1234_5678, 32'h0);               rest(0);
      send_item(OP_INSERT,  16'h0, 16'h0, 32'h0, 32'h5);                       rest(0);
      send_item(OP_NEAREST, 16'h0, 16'h0, 32'hdead_beef, 32'h1);               rest(0);
      send_item(OP_NEAREST, 16'h1, 16'hffff, 32'h0, 32'h0);                    rest(0);
      send_item(OP_MINCOST, 16'h8000, 16'h7fff, 32'hffff_ffff, 32'hffff_ffff); rest(0);
      send_item(OP_UNUSED,  16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff); rest(0);
      send_item(OP_NEAREST, 16'h8000, 16'h7fff, 32'h0, 32'h0);                 rest(0);
      send_item(OP_INSERT,  16'hffff, 16'h0001, 32'haaaa_aaaa, 32'h8000_0000); rest(0);
      send_item(OP_NEAREST, 16'hffff, 16'h0001, 32'h0, 32'h0);                 rest(0);
      send_item(OP_MINCOST, 16'h0, 16'h0, 32'h0, 32'h0);
      drain();

      burst = 0;
      for (int n = 0; n < ITEM_TARGET; n++) begin
         if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
         if (n > 0 && n % 600 == 0) drain();
         r = $urandom_range(0, 99);
         if (r < 12) op = OP_INSERT;
         else if (r < 54) op = OP_NEAREST;
         else if (r < 95) op = OP_MINCOST;
         else op = OP_UNUSED;
         pick_point(x, y);
         send_item(op, x, y, pick_id(), pick_cost());
         rest(burst);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
